FILE: rtl/ms_pkg.sv
// Package for the merge sorter: default sizes shared by the top level and the bank memory.
// No dependencies.
package ms_pkg;

    // Default number of values held per set.
    localparam int DEPTH_DEF = 64;

    // Default width of one value in bits.
    localparam int VALUE_BITS_DEF = 16;

endpackage

FILE: rtl/ms_bank.sv
// Bank memory for the merge sorter: one write port and two synchronous read ports.
// The read data is registered, so it arrives in the cycle after the address.
// Depends on ms_pkg for its default sizes.
module ms_bank #(
    parameter int DEPTH      = ms_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ms_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]     rd_addr_a,
    input  logic [ADDR_W-1:0]     rd_addr_b,
    output logic [VALUE_BITS-1:0] rd_data_a,
    output logic [VALUE_BITS-1:0] rd_data_b
);
    import ms_pkg::*;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: rtl/merge_sorter.sv
// Loading writes the items into bank 0; after the item marked last, the n values are sorted
// by merging pairs of runs between the two banks over ceil(log2 n) passes, each pair set
// up in ST_PAIR and merged in ST_MERGE, then read out after the ST_OUT_SETUP state.
// Only one set is handled at a time: the single merge unit moves one value per cycle
// between the two banks while it merges a pair of runs, and loading waits for the readout.
// Reset clears the control state only; bank contents are undefined until written.
module merge_sorter #(
    parameter int DEPTH      = ms_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ms_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] sorted_value,
    output logic                  final_res,
    output logic                  overflow
);
    import ms_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 2;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAIR,
        ST_MERGE,
        ST_OUT_SETUP,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_reg, src_next;

    // Bank ports.
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b, wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en0, wr_en1;
    logic [VALUE_BITS-1:0] rd_a0, rd_b0, rd_a1, rd_b1;
    logic [VALUE_BITS-1:0] head_a, head_b;

    // Handshake and helper terms.
    logic                  in_fire, out_fire, store_ok;
    logic [SUM_W-1:0]      mid_sum, hi_sum;
    logic [CNT_W-1:0]      mid_calc, hi_calc;
    logic                  a_done, b_done, take_a;
    logic [CNT_W-1:0]      a_adv, b_adv, k_inc, a_inc;
    logic [CNT_W:0]        width_dbl;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid & out_ready;
    assign store_ok  = (cnt_reg < DEPTH_C);

    // Heads of the two runs come from the bank that holds the current data.
    assign head_a = src_reg ? rd_a1 : rd_a0;
    assign head_b = src_reg ? rd_b1 : rd_b0;

    // Bounds of the next pair of runs, clipped to the set size.
    assign mid_sum  = SUM_W'(lo_reg) + SUM_W'(width_reg);
    assign hi_sum   = SUM_W'(lo_reg) + (SUM_W'(width_reg) << 1);
    assign mid_calc = (mid_sum > SUM_W'(cnt_reg)) ? cnt_reg : mid_sum[CNT_W-1:0];
    assign hi_calc  = (hi_sum > SUM_W'(cnt_reg)) ? cnt_reg : hi_sum[CNT_W-1:0];

    // Merge step: take the smaller head; an exhausted run never wins.
    assign a_done = (a_reg == mid_reg);
    assign b_done = (b_reg == hi_reg);
    assign take_a = !a_done && (b_done || (head_a < head_b));
    assign a_adv  = take_a ? (a_reg + ONE_C) : a_reg;
    assign b_adv  = take_a ? b_reg : (b_reg + ONE_C);
    assign k_inc  = k_reg + ONE_C;
    assign a_inc  = a_reg + ONE_C;
    assign width_dbl = {1'b0, width_reg} << 1;

    // Read addresses are issued ahead of the data they fetch, as the bank read ports are registered.
    always_comb
    begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (state_reg)
            ST_PAIR:
            begin
                rd_addr_a = lo_reg[ADDR_W-1:0];
                rd_addr_b = mid_calc[ADDR_W-1:0];
            end
            ST_MERGE:
            begin
                rd_addr_a = a_adv[ADDR_W-1:0];
                rd_addr_b = b_adv[ADDR_W-1:0];
            end
            ST_OUT:
            begin
                rd_addr_a = out_fire ? a_inc[ADDR_W-1:0] : a_reg[ADDR_W-1:0];
            end
            default:
            begin
                rd_addr_a = '0;
                rd_addr_b = '0;
            end
        endcase
    end

    // Loading writes bank 0; a merge writes the bank that is not the source.
    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            wr_addr = cnt_reg[ADDR_W-1:0];
            wr_data = value;
        end
        else
        begin
            wr_addr = k_reg[ADDR_W-1:0];
            wr_data = take_a ? head_a : head_b;
        end
    end

    assign wr_en0 = (in_fire && store_ok) || ((state_reg == ST_MERGE) && src_reg);
    assign wr_en1 = (state_reg == ST_MERGE) && !src_reg;

    ms_bank #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_bank0 (
        .clk       (clk),
        .wr_en     (wr_en0),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a0),
        .rd_data_b (rd_b0)
    );

    ms_bank #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_bank1 (
        .clk       (clk),
        .wr_en     (wr_en1),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a1),
        .rd_data_b (rd_b1)
    );

    // Sequencer for loading, the merge passes and the readout.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_ok)
                    begin
                        cnt_next = cnt_reg + ONE_C;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        width_next = ONE_C;
                        lo_next    = '0;
                        src_next   = 1'b0;
                        if (cnt_next <= ONE_C)
                        begin
                            state_next = ST_OUT_SETUP;
                        end
                        else
                        begin
                            state_next = ST_PAIR;
                        end
                    end
                end
            end
            ST_PAIR:
            begin
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                a_next     = lo_reg;
                b_next     = mid_calc;
                k_next     = lo_reg;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                a_next = a_adv;
                b_next = b_adv;
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == cnt_reg)
                    begin
                        // Pass complete: the written bank becomes the source.
                        src_next = !src_reg;
                        lo_next  = '0;
                        if (width_dbl >= {1'b0, cnt_reg})
                        begin
                            state_next = ST_OUT_SETUP;
                        end
                        else
                        begin
                            width_next = width_dbl[CNT_W-1:0];
                            state_next = ST_PAIR;
                        end
                    end
                    else
                    begin
                        lo_next    = hi_reg;
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_OUT_SETUP:
            begin
                a_next     = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    a_next = a_inc;
                    if (a_inc == cnt_reg)
                    begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            width_reg   <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            src_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
            src_reg     <= src_next;
        end
    end

    // Result item fields.
    assign sorted_value = head_a;
    assign final_res    = (a_inc == cnt_reg);
    assign overflow     = dropped_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for merge_sorter: loads sets of values, predicts the ascending output
// of each set, and checks every result. Depends on ms_pkg and the merge_sorter RTL.
module testbench;

    localparam int DEPTH = ms_pkg::DEPTH_DEF;
    localparam int VW = ms_pkg::VALUE_BITS_DEF;
    localparam int DRAIN_CYCLES = 600;

    typedef logic [VW-1:0] value_t;

    typedef struct packed {
        value_t val;
        logic   fin;
        logic   ovf;
    } sorted_rec_t;

    typedef enum int {VAL_FULL, VAL_DUPS, VAL_EDGES} val_mode_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    value_t value = '0;
    logic   last = 1'b0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    value_t sorted_value;
    logic   final_res;
    logic   overflow;

    // Expected sorted results, oldest first.
    sorted_rec_t pending_sorted[$];

    // Predictor copy of the set being loaded, kept in ascending order.
    value_t held_vals[0:DEPTH-1];
    int     held_cnt = 0;
    bit     held_dropped = 1'b0;

    bit tx_gap_en = 1'b1;
    bit rx_stall_en = 1'b1;

    int errors = 0;
    int n_items = 0;
    int n_sets = 0;
    int n_results = 0;
    int n_overflow_sets = 0;

    merge_sorter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic value_t pick_value(input val_mode_t mode);
        case (mode)
            VAL_DUPS:
                return value_t'($urandom_range(0, 7));
            VAL_EDGES:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return value_t'(1) << $urandom_range(0, VW - 1);
                    default: return value_t'($urandom);
                endcase
            default:
                return value_t'($urandom);
        endcase
    endfunction

    // Accepts one value into the predicted set; on the last value the whole set is
    // released as expected results in ascending order and the set is cleared.
    function automatic void load_value(input value_t v, input logic l);
        int pos;
        int k;
        sorted_rec_t rec;
        if (held_cnt < DEPTH)
        begin
            pos = held_cnt;
            while (pos > 0 && held_vals[pos-1] > v)
            begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = v;
            held_cnt++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (l)
        begin
            for (k = 0; k < held_cnt; k++)
            begin
                rec.val = held_vals[k];
                rec.fin = (k == held_cnt - 1);
                rec.ovf = held_dropped;
                pending_sorted = {pending_sorted, rec};
            end
            n_sets++;
            if (held_dropped)
                n_overflow_sets++;
            held_cnt = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // Sends one item and waits for it to be accepted.
    task automatic send_item(input value_t v, input logic l);
        int gap;
        gap = tx_gap_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        load_value(v, l);
        n_items++;
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls of varied length while enabled.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!rx_stall_en || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sorted_rec_t exp_rec;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_sorted.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%h final=%b overflow=%b",
                         $time, sorted_value, final_res, overflow);
            end
            else
            begin
                exp_rec = pending_sorted.pop_front();
                if (sorted_value !== exp_rec.val)
                begin
                    errors++;
                    $display("%0t: sorted_value expected %h actual %h",
                             $time, exp_rec.val, sorted_value);
                end
                if (final_res !== exp_rec.fin)
                begin
                    errors++;
                    $display("%0t: final_res expected %b actual %b",
                             $time, exp_rec.fin, final_res);
                end
                if (overflow !== exp_rec.ovf)
                begin
                    errors++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_rec.ovf, overflow);
                end
            end
        end
    end

    // Sets of one value each: both ends of the range and one value between them.
    task automatic test_single_values();
        send_item('0, 1'b1);
        send_item('1, 1'b1);
        send_item(value_t'(16'hA5A5), 1'b1);
    endtask

    // One set that puts every bit of the value at both levels.
    task automatic test_extremes();
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(value_t'(16'h5555), 1'b0);
        send_item(value_t'(16'hAAAA), 1'b0);
        send_item(value_t'(16'h8000), 1'b0);
        send_item(value_t'(16'h0001), 1'b0);
        send_item(value_t'(16'h7FFF), 1'b1);
    endtask

    // Repeated values must come out as repeats.
    task automatic test_duplicates();
        send_item(value_t'(16'h1234), 1'b0);
        send_item(value_t'(16'h1234), 1'b0);
        send_item('0, 1'b0);
        send_item(value_t'(16'h1234), 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b1);
    endtask

    // Strictly descending input in one set.
    task automatic test_descending();
        int i;
        for (i = 5; i >= 1; i--)
            send_item(value_t'(i * 10), i == 1);
    endtask

    // Random sets, mostly small, with varied value patterns and idling.
    task automatic test_random_sets();
        int sent;
        int set_no;
        int set_size;
        int i;
        int r;
        val_mode_t mode;
        sent = 0;
        set_no = 0;
        while (sent < 85)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                set_size = $urandom_range(1, 6);
            else if (r < 95)
                set_size = $urandom_range(7, 16);
            else
                set_size = $urandom_range(17, 40);
            mode = val_mode_t'($urandom_range(0, 2));
            tx_gap_en = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            for (i = 0; i < set_size; i++)
                send_item(pick_value(mode), i == set_size - 1);
            sent += set_size;
            set_no++;
            // Let the sorter go fully idle once in the middle of the stream.
            if (set_no == 5)
                wait_drained();
        end
    endtask

    // Fill the store completely, then keep sending so the tail, last one included, is dropped.
    task automatic test_store_limit();
        int i;
        tx_gap_en = 1'b1;
        rx_stall_en = 1'b1;
        for (i = 0; i < DEPTH + 2; i++)
            send_item(pick_value(VAL_FULL), i == DEPTH + 1);
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_values();
        test_extremes();
        test_duplicates();
        test_descending();
        wait_drained();
        test_random_sets();
        test_store_limit();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d items in %0d sets, %0d of them with dropped values,",
                 n_items, n_sets, n_overflow_sets);
        $display("and checked %0d sorted results.", n_results);
        if (errors == 0 && pending_sorted.size() == 0)
            $display("merge_sorter: match");
        else
            $display("merge_sorter: mismatch");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #2000000;
        $display("merge_sorter: mismatch");
        $finish;
    end

endmodule
